@@ rtl/assert_macros.svh @@
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define DEQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition never holds while reset is released.
`define DEQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `DEQ_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

@@ rtl/deq_pkg.sv @@
// Package with the constants, codes and interface types of the deque.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // accept the input transaction and update the deque
        logic capture;  // latch the word read from the slot memory
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;   // the offered transaction is a pop that will succeed
    } deq_stat_t;

endpackage
`default_nettype wire

@@ rtl/deq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/deq_ctrl.sv @@
// Controller state machine of the deque: handshakes and sequencing of a transaction.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire deq_stat_t stat,
    output deq_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   load;

    // A new transaction may enter as soon as the pending result leaves.
    assign s_ready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && m_ready);
    assign m_valid = (state_reg == S_RESP);
    assign load    = s_valid && s_ready;

    assign cmd.load    = load;
    assign cmd.capture = (state_reg == S_READ);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (load) begin
                    state_next = stat.pop_ok ? S_READ : S_RESP;
                end
            end
            S_READ: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (load) begin
                    state_next = stat.pop_ok ? S_READ : S_RESP;
                end else if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/deq_dp.sv @@
// Datapath of the deque: ring pointers, occupancy count, slot memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module deq_dp
    import deq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire deq_cmd_t            cmd,
    output deq_stat_t                stat,
    input  wire logic [ACTION_W-1:0] s_action,
    input  wire logic [DATA_W-1:0]   s_push_value,
    output logic      [DATA_W-1:0]   m_pop_value,
    output logic      [STATUS_W-1:0] m_status,
    output logic      [OCC_W-1:0]    m_occupancy,
    output logic                     m_is_empty
);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0]  front_reg, front_next;
    logic [PTR_W-1:0]  back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] pop_value_reg;
    status_t           status_reg, status_next;
    logic [OCC_W-1:0]  occupancy_reg;
    logic              is_empty_reg;

    logic [PTR_W-1:0]  front_prev, front_succ, back_prev, back_succ;
    logic              is_full, is_empty_now;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    action_t           action;

    assign action       = action_t'(s_action);
    assign front_prev   = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_succ   = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign back_prev    = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;
    assign back_succ    = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign is_full      = (count_reg == FULL_CNT);
    assign is_empty_now = (count_reg == '0);

    assign stat.pop_ok = s_action[1] && !is_empty_now;

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        ram_we      = 1'b0;
        ram_waddr   = back_reg;
        ram_raddr   = front_reg;
        unique case (action)
            ACT_PUSH_FRONT: begin
                ram_waddr = front_prev;
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    ram_we     = cmd.load;
                    front_next = front_prev;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    ram_we     = cmd.load;
                    back_next  = back_succ;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty_now) begin
                    status_next = ST_EMPTY;
                end else begin
                    front_next = front_succ;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                ram_raddr = back_prev;
                if (is_empty_now) begin
                    status_next = ST_EMPTY;
                end else begin
                    back_next  = back_prev;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_push_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.load) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Result registers; the popped word is captured from the registered read of the slot memory in the read state.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pop_value_reg <= '0;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
            is_empty_reg  <= (count_next == '0);
        end else if (cmd.capture) begin
            pop_value_reg <= ram_rdata;
        end
    end

    assign m_pop_value = pop_value_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occupancy_reg;
    assign m_is_empty  = is_empty_reg;

endmodule
`default_nettype wire

@@ rtl/double_ended_queue_top.sv @@
// Bounded double-ended queue of signed 32-bit words: top level.
//
// Input channel (s_valid/s_ready): s_action selects push front, push back,
// pop front or pop back; s_push_value is the word stored by a push.
// Result channel (m_valid/m_ready): one result transaction per input
// transaction with the popped word (zero unless a pop succeeds), a status
// code (ok, pop on empty, push on full), the occupancy after the operation
// and an empty flag.
// A push or a failed operation registers its result at acceptance; a
// successful pop first passes through a read state for the registered read
// of the slot memory. A push or failed operation can be accepted in the same
// cycle the previous result is taken, so those run at one per cycle while
// the receiver takes results; no transaction is accepted in the read state.
// Reset (aresetn low, synchronous) empties the deque and drops any pending
// result; slot contents are not cleared. While the receiver stalls, the
// result is held and no new transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue_top
    import deq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [ACTION_W-1:0] s_action,
    input  wire logic [DATA_W-1:0]   s_push_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [DATA_W-1:0]   m_pop_value,
    output logic      [STATUS_W-1:0] m_status,
    output logic      [OCC_W-1:0]    m_occupancy,
    output logic                     m_is_empty
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    deq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_action    (s_action),
        .s_push_value(s_push_value),
        .m_pop_value (m_pop_value),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .m_is_empty  (m_is_empty)
    );

    // A failed pop reports nothing removed from an empty deque.
    `DEQ_ASSERT(a_empty_pop, aclk, aresetn, (m_valid && (m_status == ST_EMPTY)) |-> ((m_pop_value == '0) && m_is_empty), "pop on empty returned data")
    // A refused push only happens at full occupancy.
    `DEQ_ASSERT(a_full_push, aclk, aresetn, (m_valid && (m_status == ST_FULL)) |-> (m_occupancy == OCC_W'(DEPTH)), "push refused below full")
    // After an accepted transaction the block either presents a result or is still reading.
    `DEQ_ASSERT(a_accept_flow, aclk, aresetn, (s_valid && s_ready) |=> (m_valid || !s_ready), "accepted transaction lost")
    // The empty flag agrees with the reported occupancy.
    `DEQ_ASSERT_NEVER(a_empty_flag, aclk, aresetn, m_valid && (m_is_empty != (m_occupancy == '0)), "empty flag disagrees with occupancy")

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps
module tb;
    import deq_pkg::*;

    localparam int RANDOM_OPS = 1726;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [DATA_W-1:0] pop_value;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } deque_result_t;

    typedef struct {
        action_t           action;
        logic [DATA_W-1:0] word;
        bit                drain_first;
    } deque_op_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action = ACT_PUSH_FRONT;
    logic [DATA_W-1:0]   s_push_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [DATA_W-1:0]   m_pop_value;
    logic [STATUS_W-1:0] m_status;
    logic [OCC_W-1:0]    m_occupancy;
    logic                m_is_empty;

    // Mirror of the deque contents.
    logic [DATA_W-1:0] mirror_slots [DEPTH];
    logic [PTR_W-1:0]  mirror_front = '0;
    logic [PTR_W-1:0]  mirror_back = '0;
    logic [CNT_W-1:0]  mirror_count = '0;

    deque_op_t     ops_pending [$];
    deque_result_t results_expected [$];

    int offered_count = 0;
    int accepted_count = 0;
    int error_count = 0;
    int pushes_ok = 0;
    int pops_ok = 0;
    int full_refusals = 0;
    int empty_pops = 0;
    int peak_occupancy = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rcv_cycle = 0;
    int rcv_mode = 0;
    int hold_left = 0;
    int holds_done = 0;

    double_ended_queue_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy),
        .m_is_empty   (m_is_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", results_expected.size());
        $display("double_ended_queue_top: mismatch");
        $finish;
    end

    // Applies one operation to the mirror and returns the result it must produce.
    function automatic deque_result_t deque_apply(action_t act, logic [DATA_W-1:0] word);
        deque_result_t r;
        r.pop_value = '0;
        r.status = ST_OK;
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
            if (mirror_count >= DEPTH) begin
                r.status = ST_FULL;
            end else if (act == ACT_PUSH_FRONT) begin
                mirror_front = mirror_front - 1'b1;
                mirror_slots[mirror_front] = word;
                mirror_count = mirror_count + 1'b1;
            end else begin
                mirror_slots[mirror_back] = word;
                mirror_back = mirror_back + 1'b1;
                mirror_count = mirror_count + 1'b1;
            end
        end else begin
            if (mirror_count == 0) begin
                r.status = ST_EMPTY;
            end else if (act == ACT_POP_FRONT) begin
                r.pop_value = mirror_slots[mirror_front];
                mirror_front = mirror_front + 1'b1;
                mirror_count = mirror_count - 1'b1;
            end else begin
                mirror_back = mirror_back - 1'b1;
                r.pop_value = mirror_slots[mirror_back];
                mirror_count = mirror_count - 1'b1;
            end
        end
        r.occupancy = OCC_W'(mirror_count);
        r.is_empty = (mirror_count == 0);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return DATA_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input action_t act, input logic [DATA_W-1:0] word,
                          input bit drain);
        deque_op_t op;
        op.action = act;
        op.word = word;
        op.drain_first = drain;
        ops_pending.push_back(op);
    endtask

    task automatic report(input string what);
        if (error_count < 30) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge aclk) begin : driver
        deque_op_t op;
        if (aresetn && offered_count == accepted_count) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (ops_pending.size() > 0 &&
                         (!ops_pending[0].drain_first || results_expected.size() == 0)) begin
                op = ops_pending.pop_front();
                s_valid <= 1'b1;
                s_action <= op.action;
                s_push_value <= op.word;
                offered_count++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: changes its stall pattern now and then and periodically holds
    // off for a long stretch.
    always @(negedge aclk) begin : receiver
        rcv_cycle++;
        if (rcv_cycle % 3000 == 1500) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (rcv_cycle % 400 == 0) begin
            rcv_mode = $urandom_range(0, 2);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rcv_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        deque_result_t want;
        if (aresetn) begin
            // The result of a transaction accepted at this edge cannot appear
            // before the next one, so results are checked first.
            if (m_valid && m_ready) begin
                if (results_expected.size() == 0) begin
                    report("result transaction with nothing outstanding");
                end else begin
                    want = results_expected.pop_front();
                    if (m_pop_value !== want.pop_value)
                        report($sformatf("pop_value %h, predicted %h",
                                         m_pop_value, want.pop_value));
                    if (m_status !== want.status)
                        report($sformatf("status %0d, predicted %0d", m_status, want.status));
                    if (m_occupancy !== want.occupancy)
                        report($sformatf("occupancy %0d, predicted %0d",
                                         m_occupancy, want.occupancy));
                    if (m_is_empty !== want.is_empty)
                        report($sformatf("is_empty %b, predicted %b",
                                         m_is_empty, want.is_empty));
                end
            end
            if (s_valid && s_ready) begin
                want = deque_apply(action_t'(s_action), s_push_value);
                results_expected.push_back(want);
                accepted_count++;
                case (want.status)
                    ST_FULL:  full_refusals++;
                    ST_EMPTY: empty_pops++;
                    default: begin
                        if (s_action == ACT_PUSH_FRONT || s_action == ACT_PUSH_BACK)
                            pushes_ok++;
                        else
                            pops_ok++;
                    end
                endcase
                if (want.occupancy > peak_occupancy) peak_occupancy = want.occupancy;
            end
        end
    end

    initial begin : main
        int n;
        int seg_len;
        int push_pct;
        action_t act;
        // Directed part: empty pops, extreme words, a fill to capacity and
        // refused pushes on both ends.
        add_op(ACT_POP_FRONT, '0, 1'b0);
        add_op(ACT_POP_BACK, '1, 1'b0);
        add_op(ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
        add_op(ACT_PUSH_BACK, 32'h8000_0000, 1'b0);
        add_op(ACT_POP_BACK, '0, 1'b0);
        add_op(ACT_POP_FRONT, '0, 1'b0);
        for (int i = 0; i < DEPTH; i++) begin
            add_op(action_t'((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT),
                   (i % 2) ? ~(32'h0101_0101 * i) : 32'h0101_0101 * i, 1'b0);
        end
        add_op(ACT_PUSH_FRONT, 32'hDEAD_0001, 1'b0);
        add_op(ACT_PUSH_BACK, 32'hDEAD_0002, 1'b0);

        // Random part: segments that lean toward pushes or pops so that the
        // deque swings between full and empty with wrapped pointers.
        n = 0;
        while (n < RANDOM_OPS) begin
            seg_len = $urandom_range(5, 60);
            case ($urandom_range(0, 4))
                0: push_pct = 90;
                1: push_pct = 70;
                2: push_pct = 50;
                3: push_pct = 30;
                default: push_pct = 10;
            endcase
            for (int k = 0; k < seg_len && n < RANDOM_OPS; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    act = action_t'($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT);
                else
                    act = action_t'($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT);
                add_op(act, random_word(), (n == 600 || n == 1300));
                n++;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (ops_pending.size() != 0 || offered_count != accepted_count) @(posedge aclk);
        while (results_expected.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Ran %0d transactions: %0d pushes, %0d pops, %0d refused on full, %0d pops on empty.",
                 accepted_count, pushes_ok, pops_ok, full_refusals, empty_pops);
        $display("Peak occupancy %0d of %0d, %0d long receiver hold-offs.",
                 peak_occupancy, DEPTH, holds_done);
        if (error_count == 0) begin
            $display("double_ended_queue_top: match");
        end else begin
            $display("double_ended_queue_top: mismatch");
        end
        $finish;
    end

endmodule
